/* hdl/mppt_po_pkg.sv */
`default_nettype none

package mppt_po_pkg;

  localparam int unsigned VoltW  = 16;
  localparam int unsigned CurrW  = 16;
  localparam int unsigned PowerW = 32;
  localparam int unsigned CfgW   = 32;
  localparam int unsigned IdxW   = 3;

  // Wide enough for voltage plus or minus step without wrapping
  localparam int unsigned TargW  = VoltW + 2;
  // Wide enough for the signed power change and the negated deadband
  localparam int unsigned DeltaW = PowerW + 2;

  localparam logic [VoltW-1:0]  ResetTargetMv = 16'd20000;
  localparam logic [VoltW-1:0]  ResetStepMv   = 16'd100;
  localparam logic [VoltW-1:0]  ResetMinMv    = 16'd15000;
  localparam logic [VoltW-1:0]  ResetMaxMv    = 16'd25000;
  localparam logic [PowerW-1:0] ResetDbandUw  = 32'd10000;

  typedef enum logic [IdxW-1:0] {
    REG_ENABLE   = 3'd0,
    REG_STEP     = 3'd1,
    REG_MIN_TARG = 3'd2,
    REG_MAX_TARG = 3'd3,
    REG_DEADBAND = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic              enable;
    logic [VoltW-1:0]  step_mv;
    logic [VoltW-1:0]  min_target_mv;
    logic [VoltW-1:0]  max_target_mv;
    logic [PowerW-1:0] power_deadband_uw;
  } cfg_t;

  typedef struct packed {
    logic [PowerW-1:0] prev_power_uw;
    logic [VoltW-1:0]  target_mv;
    logic              first_sample;
  } trk_state_t;

endpackage

`default_nettype wire

/* hdl/mppt_po_sample_if.sv */
`default_nettype none

interface mppt_po_sample_if;
  import mppt_po_pkg::*;

  logic             valid;
  logic             ready;
  logic [VoltW-1:0] voltage_mv;
  logic [CurrW-1:0] current_ma;

  modport source (output valid, output voltage_mv, output current_ma, input ready);
  modport sink   (input valid, input voltage_mv, input current_ma, output ready);
endinterface

`default_nettype wire

/* hdl/mppt_po_result_if.sv */
`default_nettype none

interface mppt_po_result_if;
  import mppt_po_pkg::*;

  logic              valid;
  logic              ready;
  logic [VoltW-1:0]  target_mv;
  logic [PowerW-1:0] power_uw;

  modport source (output valid, output target_mv, output power_uw, input ready);
  modport sink   (input valid, input target_mv, input power_uw, output ready);
endinterface

`default_nettype wire

/* hdl/mppt_po_update.sv */
`default_nettype none

module mppt_po_update (
  input  mppt_po_pkg::cfg_t                      cfg_i,
  input  mppt_po_pkg::trk_state_t                cur_i,
  input  logic [mppt_po_pkg::VoltW-1:0]          voltage_mv_i,
  input  logic [mppt_po_pkg::PowerW-1:0]         power_uw_i,
  output mppt_po_pkg::trk_state_t                nxt_o
);
  import mppt_po_pkg::*;

  logic signed [DeltaW-1:0] delta_p;
  logic signed [DeltaW-1:0] dband;
  logic signed [TargW-1:0]  volt_s;
  logic signed [TargW-1:0]  step_s;
  logic signed [TargW-1:0]  min_s;
  logic signed [TargW-1:0]  max_s;
  logic signed [TargW-1:0]  targ_raw;
  logic signed [TargW-1:0]  targ_lo;
  logic signed [TargW-1:0]  targ_cl;

  assign delta_p = $signed({2'b00, power_uw_i}) - $signed({2'b00, cur_i.prev_power_uw});
  assign dband   = $signed({2'b00, cfg_i.power_deadband_uw});
  assign volt_s  = $signed({2'b00, voltage_mv_i});
  assign step_s  = $signed({2'b00, cfg_i.step_mv});
  assign min_s   = $signed({2'b00, cfg_i.min_target_mv});
  assign max_s   = $signed({2'b00, cfg_i.max_target_mv});

  always_comb begin
    if (cur_i.first_sample) begin
      targ_raw = volt_s;
    end else if (delta_p > dband) begin
      targ_raw = volt_s + step_s;
    end else if (delta_p < -dband) begin
      targ_raw = volt_s - step_s;
    end else begin
      targ_raw = $signed({2'b00, cur_i.target_mv});
    end
  end

  // Minimum first, maximum last: max wins when the limits cross
  assign targ_lo = (targ_raw < min_s) ? min_s : targ_raw;
  assign targ_cl = (targ_lo > max_s) ? max_s : targ_lo;

  always_comb begin
    nxt_o = cur_i;
    if (cfg_i.enable) begin
      nxt_o.target_mv    = targ_cl[VoltW-1:0];
      nxt_o.first_sample = 1'b0;
      if (!cur_i.first_sample) begin
        nxt_o.prev_power_uw = power_uw_i;
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/mppt_perturb_observe.sv */
// Perturb-and-observe maximum power point tracker.
//
// sample_i carries one panel voltage (mV) and current (mA) per item; result_o
// returns one item per sample: the clamped voltage target (mV) and the stored
// panel power (uW). Both channels use valid/ready; an item moves on a rising
// edge with both high. Registers are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i, only while no item is in flight, a rule the block leaves to the user.
//
// Result valid rises once the sample has passed the sample stage and the
// result register. The first stage registers the voltage and the 16x16
// product, the second compares the power change with the deadband, clamps
// the target and loads the result register together with the tracker state.
// One item per cycle is sustained while result_o.ready stays high.
//
// When result_o stalls, the result register holds; the sample stage still
// takes one item if it is empty, then sample_i.ready drops until the result
// is taken. Reset empties both stages, restores register defaults, sets the
// target to 20000 mV, the stored power to 0 and arms the first-sample flag.
`default_nettype none

module mppt_perturb_observe (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [mppt_po_pkg::IdxW-1:0]       cfg_idx_i,
  input  logic [mppt_po_pkg::CfgW-1:0]       cfg_wdata_i,
  mppt_po_sample_if.sink                     sample_i,
  mppt_po_result_if.source                   result_o
);
  import mppt_po_pkg::*;

  cfg_t               cfg_q;
  trk_state_t         state_q;
  trk_state_t         state_nxt;

  logic               a_valid_q;
  logic [VoltW-1:0]   a_volt_q;
  logic [PowerW-1:0]  a_power_q;
  logic [PowerW-1:0]  product;

  logic               out_valid_q;
  logic [VoltW-1:0]   out_target_q;
  logic [PowerW-1:0]  out_power_q;

  logic               b_free;
  logic               b_fire;
  logic               a_take;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable            <= 1'b1;
      cfg_q.step_mv           <= ResetStepMv;
      cfg_q.min_target_mv     <= ResetMinMv;
      cfg_q.max_target_mv     <= ResetMaxMv;
      cfg_q.power_deadband_uw <= ResetDbandUw;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ENABLE:   cfg_q.enable            <= cfg_wdata_i[0];
        REG_STEP:     cfg_q.step_mv           <= cfg_wdata_i[VoltW-1:0];
        REG_MIN_TARG: cfg_q.min_target_mv     <= cfg_wdata_i[VoltW-1:0];
        REG_MAX_TARG: cfg_q.max_target_mv     <= cfg_wdata_i[VoltW-1:0];
        REG_DEADBAND: cfg_q.power_deadband_uw <= cfg_wdata_i[PowerW-1:0];
        default: ;
      endcase
    end
  end

  assign b_free         = !out_valid_q || result_o.ready;
  assign b_fire         = a_valid_q && b_free;
  assign a_take         = !a_valid_q || b_free;
  assign sample_i.ready = a_take;

  assign product = {{(PowerW-VoltW){1'b0}}, sample_i.voltage_mv} *
                   {{(PowerW-CurrW){1'b0}}, sample_i.current_ma};

  // Sample stage: voltage and product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_take) begin
      a_valid_q <= sample_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_take && sample_i.valid) begin
      a_volt_q  <= sample_i.voltage_mv;
      a_power_q <= product;
    end
  end

  mppt_po_update u_update (
    .cfg_i        (cfg_q),
    .cur_i        (state_q),
    .voltage_mv_i (a_volt_q),
    .power_uw_i   (a_power_q),
    .nxt_o        (state_nxt)
  );

  // Tracker state advances with each item leaving the sample stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.prev_power_uw <= '0;
      state_q.target_mv     <= ResetTargetMv;
      state_q.first_sample  <= 1'b1;
    end else if (b_fire) begin
      state_q <= state_nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_free) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      out_target_q <= state_nxt.target_mv;
      out_power_q  <= state_nxt.prev_power_uw;
    end
  end

  assign result_o.valid     = out_valid_q;
  assign result_o.target_mv = out_target_q;
  assign result_o.power_uw  = out_power_q;

`ifndef SYNTHESIS
  // A held result always mirrors the tracker state
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_target_q == state_q.target_mv &&
                     out_power_q == state_q.prev_power_uw))
    else $error("result register differs from tracker state");

  a_frozen_when_disabled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && !cfg_q.enable) |=> ($stable(state_q.target_mv) &&
                                   $stable(state_q.prev_power_uw) &&
                                   $stable(state_q.first_sample)))
    else $error("tracker state moved while disabled");

  a_first_clears_on_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(state_q.first_sample) |-> $past(b_fire))
    else $error("first-sample flag cleared without an item");

  a_first_keeps_power: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_fire && state_q.first_sample) |=> $stable(state_q.prev_power_uw))
    else $error("stored power changed on the first sample");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mppt_po_pkg::*;

  localparam int ResetCycles  = 7;
  localparam int SettleCycles = 6;
  localparam int LongHold     = 400;
  localparam int CycleLimit   = 400000;
  localparam int RandPhases   = 12;
  localparam int PhaseItems   = 95;

  typedef struct packed {
    logic [VoltW-1:0] voltage_mv;
    logic [CurrW-1:0] current_ma;
  } sample_t;

  typedef struct packed {
    logic [VoltW-1:0]  target_mv;
    logic [PowerW-1:0] power_uw;
  } track_t;

  typedef enum logic [1:0] {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_PERIODIC
  } rdy_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [IdxW-1:0] cfg_idx;
  logic [CfgW-1:0] cfg_wdata;

  mppt_po_sample_if smp ();
  mppt_po_result_if res ();

  mppt_perturb_observe i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .sample_i   (smp),
    .result_o   (res)
  );

  always #1 clk_i = ~clk_i;

  // Tracker copy: configuration and state
  logic              m_enable;
  logic [VoltW-1:0]  m_step_mv;
  logic [VoltW-1:0]  m_min_mv;
  logic [VoltW-1:0]  m_max_mv;
  logic [PowerW-1:0] m_dband_uw;
  logic [PowerW-1:0] m_prev_power_uw;
  logic [VoltW-1:0]  m_target_mv;
  logic              m_first;

  sample_t sample_q[$];
  track_t  mpp_q[$];

  int fails;
  int samples_sent;
  int results_checked;
  int cfg_writes;
  int cycles;
  logic smp_took;
  logic hold_req;

  function automatic track_t track_mpp(input logic [VoltW-1:0] v, input logic [CurrW-1:0] c);
    longint t;
    longint dp;
    longint db;
    logic [PowerW-1:0] p;
    track_t r;
    if (m_enable) begin
      t = longint'(m_target_mv);
      if (m_first) begin
        t = longint'(v);
        m_first = 1'b0;
      end else begin
        p = PowerW'(v) * PowerW'(c);
        dp = longint'(p) - longint'(m_prev_power_uw);
        db = longint'(m_dband_uw);
        if (dp > db) t = longint'(v) + longint'(m_step_mv);
        else if (dp < -db) t = longint'(v) - longint'(m_step_mv);
        m_prev_power_uw = p;
      end
      // min clamp first, max clamp wins
      if (t < longint'(m_min_mv)) t = longint'(m_min_mv);
      if (t > longint'(m_max_mv)) t = longint'(m_max_mv);
      m_target_mv = t[VoltW-1:0];
    end
    r.target_mv = m_target_mv;
    r.power_uw  = m_prev_power_uw;
    return r;
  endfunction

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    case (idx)
      REG_ENABLE:   m_enable   = data[0];
      REG_STEP:     m_step_mv  = data[VoltW-1:0];
      REG_MIN_TARG: m_min_mv   = data[VoltW-1:0];
      REG_MAX_TARG: m_max_mv   = data[VoltW-1:0];
      REG_DEADBAND: m_dband_uw = data[PowerW-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic push_sample(input int v, input int c);
    sample_t s;
    s.voltage_mv = VoltW'(v);
    s.current_ma = CurrW'(c);
    sample_q.push_back(s);
  endtask

  // Hold until every item went through, then let the pipeline drain
  task automatic settle();
    while (sample_q.size() != 0 || mpp_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic random_setting();
    logic [VoltW-1:0] lo;
    logic [VoltW-1:0] hi;
    logic [CfgW-1:0]  db;
    logic [VoltW-1:0] st;
    case ($urandom_range(3))
      0: st = '0;
      1: st = VoltW'($urandom_range(1, 500));
      2: st = VoltW'($urandom);
      default: st = '1;
    endcase
    case ($urandom_range(4))
      0, 1: begin
        lo = VoltW'($urandom_range(0, 20000));
        hi = lo + VoltW'($urandom_range(0, 30000));
      end
      2: begin
        lo = VoltW'($urandom);
        hi = VoltW'($urandom);
      end
      3: begin
        lo = '0;
        hi = '1;
      end
      default: begin
        hi = VoltW'($urandom_range(0, 30000));
        lo = hi + VoltW'($urandom_range(1, 30000));
      end
    endcase
    case ($urandom_range(5))
      0: db = '0;
      1, 2: db = CfgW'($urandom_range(0, 50000));
      3: db = CfgW'($urandom_range(0, 5000000));
      4: db = $urandom;
      default: db = '1;
    endcase
    write_reg(REG_STEP, CfgW'(st));
    write_reg(REG_MIN_TARG, CfgW'(lo));
    write_reg(REG_MAX_TARG, CfgW'(hi));
    write_reg(REG_DEADBAND, db);
    write_reg(REG_ENABLE, CfgW'(($urandom_range(7) == 0) ? 1'b0 : 1'b1));
  endtask

  // Mostly a panel-like operating walk, with some raw noise and extremes
  task automatic queue_samples(input int n);
    int v_walk;
    int c;
    int r;
    v_walk = $urandom_range(5000, 60000);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(9);
      if (r < 7) begin
        v_walk = v_walk + $urandom_range(0, 600) - 300;
        if (v_walk < 0) v_walk = 0;
        if (v_walk > 65535) v_walk = 65535;
        c = (v_walk < 40000) ? $urandom_range(3000, 5000) : $urandom_range(0, 3000);
        push_sample(v_walk, c);
      end else if (r < 9) begin
        push_sample($urandom_range(65535), $urandom_range(65535));
      end else begin
        push_sample($urandom_range(1) * 65535, $urandom_range(1) * 65535);
      end
    end
  endtask

  // Sender: bursts with random gaps, item held until taken
  int burst_left;
  int gap_left;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!(smp.valid && !smp_took)) begin
        smp_took = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          smp.valid <= 1'b0;
        end else if (sample_q.size() > 0) begin
          smp.valid      <= 1'b1;
          smp.voltage_mv <= sample_q[0].voltage_mv;
          smp.current_ma <= sample_q[0].current_ma;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(50, 200)
                                                  : $urandom_range(1, 32);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          smp.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && smp.valid && smp.ready) begin
      mpp_q.push_back(track_mpp(smp.voltage_mv, smp.current_ma));
      void'(sample_q.pop_front());
      samples_sent++;
      smp_took = 1'b1;
    end
  end

  // Receiver: stall pattern changes every so often, plus long hold-offs
  rdy_mode_e rdy_mode;
  int mode_left;
  int hold_left;
  int pat_cnt;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_req) begin
        hold_left = LongHold;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else begin
        if (mode_left <= 0) begin
          rdy_mode  = rdy_mode_e'($urandom_range(3));
          mode_left = $urandom_range(32, 256);
          if ($urandom_range(63) == 0) hold_left = $urandom_range(50, 150);
        end
        mode_left--;
        pat_cnt++;
        case (rdy_mode)
          RDY_ALWAYS:   res.ready <= 1'b1;
          RDY_COIN:     res.ready <= 1'($urandom_range(1));
          RDY_SPARSE:   res.ready <= ($urandom_range(3) == 0);
          RDY_PERIODIC: res.ready <= ((pat_cnt % 3) != 0);
          default:      res.ready <= 1'b1;
        endcase
      end
    end
  end

  track_t want;

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      if (mpp_q.size() == 0) begin
        $error("result with no sample pending: target_mv %0d power_uw %0d",
               res.target_mv, res.power_uw);
        fails++;
      end else begin
        want = mpp_q.pop_front();
        if (res.target_mv !== want.target_mv) begin
          $error("target_mv mismatch: expected %0d, actual %0d", want.target_mv, res.target_mv);
          fails++;
        end
        if (res.power_uw !== want.power_uw) begin
          $error("power_uw mismatch: expected %0d, actual %0d", want.power_uw, res.power_uw);
          fails++;
        end
        results_checked++;
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    smp.valid      = 1'b0;
    smp.voltage_mv = '0;
    smp.current_ma = '0;
    res.ready      = 1'b0;
    smp_took       = 1'b0;
    hold_req       = 1'b0;
    burst_left     = $urandom_range(1, 24);
    gap_left       = 0;
    mode_left      = 0;
    hold_left      = 0;
    pat_cnt        = 0;
    rdy_mode       = RDY_ALWAYS;
    m_enable        = 1'b1;
    m_step_mv       = ResetStepMv;
    m_min_mv        = ResetMinMv;
    m_max_mv        = ResetMaxMv;
    m_dband_uw      = ResetDbandUw;
    m_prev_power_uw = '0;
    m_target_mv     = ResetTargetMv;
    m_first         = 1'b1;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Paused before the first sample: first-sample flag must survive
    write_reg(REG_ENABLE, CfgW'(1'b0));
    push_sample(65535, 65535);
    push_sample(0, 0);
    settle();
    write_reg(REG_ENABLE, CfgW'(1'b1));

    // Register defaults: first-sample clamp, field extremes, deadband edges
    push_sample(0, 0);
    push_sample(65535, 65535);
    push_sample(65535, 0);
    push_sample(20000, 1);
    push_sample(30000, 1);
    push_sample(40001, 1);
    push_sample(30001, 1);
    push_sample(20000, 1);
    push_sample(100, 1);
    settle();

    // Wide sum and difference past both ends of the target range
    write_reg(REG_STEP, CfgW'(16'hFFFF));
    write_reg(REG_MIN_TARG, '0);
    write_reg(REG_MAX_TARG, CfgW'(16'hFFFF));
    write_reg(REG_DEADBAND, '0);
    push_sample(0, 0);
    push_sample(65535, 65535);
    push_sample(65535, 65535);
    push_sample(1, 1);
    settle();

    // Minimum above maximum; unused indexes must be ignored
    write_reg(REG_STEP, '0);
    write_reg(REG_MIN_TARG, CfgW'(16'd30000));
    write_reg(REG_MAX_TARG, CfgW'(16'd20000));
    write_reg(REG_DEADBAND, '1);
    for (int k = int'(REG_DEADBAND) + 1; k < (1 << IdxW); k++) write_reg(IdxW'(k), '0);
    push_sample(12345, 54321);
    push_sample(65535, 65535);
    push_sample(0, 0);
    settle();

    for (int ph = 0; ph < RandPhases; ph++) begin
      random_setting();
      // One phase forces the receiver off while the sender keeps offering
      if (ph == 2) begin
        write_reg(REG_ENABLE, CfgW'(1'b1));
        hold_req = 1'b1;
      end
      queue_samples(PhaseItems);
      settle();
    end

    repeat (SettleCycles) @(posedge clk_i);
    $display("Tracked %0d samples over %0d register writes; %0d results checked.",
             samples_sent, cfg_writes, results_checked);
    $display("Stalls included one %0d-cycle receiver hold-off; %0d mismatches.",
             LongHold, fails);
    if (fails == 0 && mpp_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
